// ===== hdl/jacobi_symbol_64_top_defines.svh =====
// assertion macros for the jacobi symbol block checker
// depends on nothing; included by the checker file only
`ifndef JACOBI_SYMBOL_64_TOP_DEFINES_SVH
`define JACOBI_SYMBOL_64_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define JAC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define JAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/jac_pkg.sv =====
// shared types and constants for the jacobi symbol block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jac_pkg;

   // datapath word width; numerator uses WORD_BITS, modulus WORD_BITS-1
   localparam int WORD_BITS = 64;
   localparam int CNT_BITS  = $clog2(WORD_BITS);

   // field widths on the ports
   localparam int A_BITS        = 64;
   localparam int N_BITS        = 63;
   localparam int REQ_DATA_BITS = 128;
   localparam int SYM_BITS      = 2;
   localparam int RSP_DATA_BITS = 8;

   // residue classes that flip the sign
   localparam logic [2:0] MOD8_3 = 3'd3;
   localparam logic [2:0] MOD8_5 = 3'd5;
   localparam logic [1:0] MOD4_3 = 2'd3;

   // symbol codes
   localparam logic [SYM_BITS-1:0] SYM_ZERO  = 2'b00;
   localparam logic [SYM_BITS-1:0] SYM_PLUS  = 2'b01;
   localparam logic [SYM_BITS-1:0] SYM_MINUS = 2'b11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_FIX,
      ST_CHECK,
      ST_SWAP,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic fix;
      logic strip;
      logic swap;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bad;
      logic div_last;
      logic a_zero;
      logic a_odd;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== hdl/jac_ctrl.sv =====
// sequencer for the binary jacobi algorithm
// depends on jac_pkg; drives jac_dpath through cmd_type, reads sts_type
`timescale 1ns / 1ps
`default_nettype none

module jac_ctrl
   import jac_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (sts.bad) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.a_zero) begin
               state_in = ST_DONE;
            end else if (!sts.a_odd) begin
               cmd.strip = 1'b1;
            end else begin
               state_in = ST_SWAP;
            end
         end
         ST_SWAP: begin
            cmd.swap = 1'b1;
            state_in = ST_START;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/jac_dpath.sv =====
// operand registers, serial remainder unit and result register
// depends on jac_pkg; commanded by jac_ctrl
`timescale 1ns / 1ps
`default_nettype none

module jac_dpath
   import jac_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [A_BITS-1:0]   req_value_a,
   input  wire logic [N_BITS-1:0]   req_modulus_n,
   input  wire cmd_type             cmd,
   output sts_type                  sts,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output logic [SYM_BITS-1:0]      rsp_symbol,
   output logic                     rsp_invalid
);

   logic [WORD_BITS-1:0]   a_ff, a_in;
   logic [WORD_BITS-2:0]   n_ff, n_in;
   logic [WORD_BITS-1:0]   rem_ff, rem_in;
   logic [WORD_BITS-1:0]   dvd_ff, dvd_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic                   sign_ff, sign_in;
   logic                   par_ff, par_in;
   logic                   bad_ff, bad_in;
   logic                   valid_ff, valid_in;
   logic [SYM_BITS-1:0]    sym_ff, sym_in;
   logic                   inv_ff, inv_in;

   logic [WORD_BITS-2:0]   n_load;
   logic [WORD_BITS-1:0]   mag;
   logic [WORD_BITS-1:0]   rem_sh;
   logic [WORD_BITS-1:0]   n_wide;
   logic [WORD_BITS-1:0]   rem_fix;
   logic                   flip_two;
   logic                   flip_rec;

   // operand views
   always_comb begin
      n_load   = req_modulus_n[WORD_BITS-2:0];
      n_wide   = {1'b0, n_ff};
      mag      = neg_ff ? (WORD_BITS'(0) - a_ff) : a_ff;
      rem_sh   = {rem_ff[WORD_BITS-2:0], dvd_ff[WORD_BITS-1]};
      rem_fix  = (neg_ff && (rem_ff != '0))
                 ? {1'b0, n_ff - rem_ff[WORD_BITS-2:0]} : rem_ff;
      flip_two = par_ff && ((n_ff[2:0] == MOD8_3) || (n_ff[2:0] == MOD8_5));
      flip_rec = (a_ff[1:0] == MOD4_3) && (n_ff[1:0] == MOD4_3);
   end

   // next values of the working registers
   always_comb begin
      a_in    = a_ff;
      n_in    = n_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      sign_in = sign_ff;
      par_in  = par_ff;
      bad_in  = bad_ff;
      sym_in  = sym_ff;
      inv_in  = inv_ff;
      if (cmd.load) begin
         a_in    = req_value_a[WORD_BITS-1:0];
         n_in    = n_load;
         neg_in  = req_value_a[WORD_BITS-1];
         sign_in = 1'b0;
         par_in  = 1'b0;
         bad_in  = (n_load == '0) || !n_load[0];
      end
      // restart the remainder unit on the magnitude of a
      if (cmd.div_start) begin
         dvd_in = mag;
         rem_in = '0;
         cnt_in = '0;
      end
      // one restoring step: shift in a bit, subtract when it fits
      if (cmd.div_step) begin
         rem_in = (rem_sh >= n_wide) ? (rem_sh - n_wide) : rem_sh;
         dvd_in = {dvd_ff[WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_BITS'(1);
      end
      // remainder becomes a; a negative numerator folds back into 0..n-1
      if (cmd.fix) begin
         a_in = rem_fix;
      end
      // strip one factor of two, tracking parity of the count
      if (cmd.strip) begin
         a_in   = {1'b0, a_ff[WORD_BITS-1:1]};
         par_in = !par_ff;
      end
      // sign updates and operand swap
      if (cmd.swap) begin
         sign_in = sign_ff ^ flip_two ^ flip_rec;
         a_in    = n_wide;
         n_in    = a_ff[WORD_BITS-2:0];
         par_in  = 1'b0;
         neg_in  = 1'b0;
      end
      if (cmd.emit) begin
         inv_in = bad_ff;
         if (bad_ff || (n_ff != (WORD_BITS-1)'(1))) begin
            sym_in = SYM_ZERO;
         end else begin
            sym_in = sign_ff ? SYM_MINUS : SYM_PLUS;
         end
      end
   end

   // result valid
   always_comb begin
      valid_in = valid_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      sign_ff <= sign_in;
      par_ff  <= par_in;
      bad_ff  <= bad_in;
      sym_ff  <= sym_in;
      inv_ff  <= inv_in;
   end

   // status back to the sequencer
   always_comb begin
      sts.bad      = bad_ff;
      sts.div_last = (cnt_ff == CNT_BITS'(WORD_BITS - 1));
      sts.a_zero   = (a_ff == '0);
      sts.a_odd    = a_ff[0];
      sts.out_free = !valid_ff || rsp_tready;
   end

   assign rsp_tvalid  = valid_ff;
   assign rsp_symbol  = sym_ff;
   assign rsp_invalid = inv_ff;

endmodule

`default_nettype wire

// ===== hdl/jacobi_symbol_64_top.sv =====
// jacobi symbol (a/n), binary algorithm; one transfer in, one out.
// each round runs start, 64 remainder steps, fold, test, then swap or emit,
// with one more test step per stripped factor of two; a bad modulus goes from
// start straight to emit.
// throughput: one item at a time; the next is taken while a result waits.
// reset: synchronous, active high; clears the sequencer and the result valid.
`timescale 1ns / 1ps
`default_nettype none

module jacobi_symbol_64_top
   import jac_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,  // value_a[63:0], modulus_n[126:64], zero
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,  // symbol[1:0], zero
   output logic [0:0]                    rsp_tuser   // invalid[0]
);

   cmd_type             cmd;
   sts_type             sts;
   logic [SYM_BITS-1:0] symbol;
   logic                invalid;

   jac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   jac_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_value_a   (req_tdata[A_BITS-1:0]),
      .req_modulus_n (req_tdata[A_BITS+N_BITS-1:A_BITS]),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_symbol    (symbol),
      .rsp_invalid   (invalid)
   );

   // pack the result transfer
   assign rsp_tdata = {(RSP_DATA_BITS-SYM_BITS)'(0), symbol};
   assign rsp_tuser = invalid;

endmodule

`default_nettype wire

// ===== hdl/jac_check.sv =====
// port-level checker for the jacobi symbol block, bound to the top level
// depends on jac_pkg and jacobi_symbol_64_top_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "jacobi_symbol_64_top_defines.svh"

module jac_check
   import jac_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic [0:0]               rsp_tuser
);

   // invalid modulus always reports a zero symbol
   `JAC_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0, "invalid result with nonzero symbol")

   // symbol is -1, 0 or 1 and the pad bits are zero
   `JAC_ASSERT_NOW(a_symbol_code, clock, reset, rsp_tvalid, (rsp_tdata[1:0] != 2'b10) && (rsp_tdata[RSP_DATA_BITS-1:SYM_BITS] == '0), "bad symbol code")

   // the block is busy in the cycle after taking an item
   `JAC_ASSERT_NEXT(a_busy_after_take, clock, reset, req_tvalid && req_tready, !req_tready, "ready right after a transfer")

   // a stalled result holds
   `JAC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind jacobi_symbol_64_top jac_check u_check (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for jacobi_symbol_64_top: directed corner transfers, then random ones
// checked by a scoreboard that predicts each symbol; depends on jac_pkg and the top module

module testbench;
   import jac_pkg::*;

   localparam int WATCHDOG_LIMIT = 60000;
   localparam int HOLD_CYCLES    = 10000;
   localparam int TAIL_CYCLES    = 6500;
   localparam int RANDOM_ITEMS   = 730;
   localparam int DRAIN_AT_ITEM  = 300;
   localparam int HOLD_AT_RESULT = 150;

   localparam logic [A_BITS-1:0] A_MIN = 64'h8000_0000_0000_0000;
   localparam logic [A_BITS-1:0] A_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [N_BITS-1:0] N_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

   // expected symbols, oldest first, and the mismatch count
   class jac_scoreboard;
      typedef struct packed {
         logic [A_BITS-1:0]   value_a;
         logic [N_BITS-1:0]   modulus_n;
         logic [SYM_BITS-1:0] symbol;
         logic                invalid;
      } symbol_entry_type;

      symbol_entry_type symbol_q[$];
      int mismatches;

      function new();
         mismatches = 0;
      endfunction

      // jacobi symbol by the binary algorithm, 64-bit numerator
      static function symbol_entry_type predict_symbol(logic [A_BITS-1:0] a_bits,
                                                       logic [N_BITS-1:0] n_field);
         symbol_entry_type res;
         logic [63:0]   n, mag, x, y, tmp;
         logic [2:0]    d;
         int unsigned   k;
         logic          flip;
         res.value_a   = a_bits;
         res.modulus_n = n_field;
         n = {1'b0, n_field};
         if (n == 0 || n[0] == 1'b0) begin
            res.symbol  = SYM_ZERO;
            res.invalid = 1'b1;
            return res;
         end
         // fold a into 0..n-1, correcting a negative remainder
         mag = a_bits[63] ? (64'd0 - a_bits) : a_bits;
         x = mag % n;
         if (a_bits[63] && x != 0) x = n - x;
         y = n;
         flip = 1'b0;
         while (x != 0) begin
            k = 0;
            while (x[0] == 1'b0) begin
               x = x >> 1;
               k++;
            end
            d = y[2:0];
            if (k[0] && (d == MOD8_3 || d == MOD8_5)) flip = ~flip;
            if (x[1:0] == MOD4_3 && d[1:0] == MOD4_3) flip = ~flip;
            tmp = x;
            x = y;
            y = tmp;
            x = x % y;
         end
         if (y == 1) res.symbol = flip ? SYM_MINUS : SYM_PLUS;
         else        res.symbol = SYM_ZERO;
         res.invalid = 1'b0;
         return res;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      function void note_request(logic [REQ_DATA_BITS-1:0] tdata);
         symbol_q.push_back(predict_symbol(tdata[63:0], tdata[126:64]));
      endfunction

      task check_response(logic [RSP_DATA_BITS-1:0] tdata, logic invalid);
         symbol_entry_type want;
         if (symbol_q.size() == 0) begin
            report($sformatf("result symbol=%b invalid=%b with nothing pending",
                             tdata[SYM_BITS-1:0], invalid));
            return;
         end
         want = symbol_q.pop_front();
         if (tdata[SYM_BITS-1:0] !== want.symbol)
            report($sformatf("a=%h n=%h symbol got %b want %b", want.value_a,
                             want.modulus_n, tdata[SYM_BITS-1:0], want.symbol));
         if (invalid !== want.invalid)
            report($sformatf("a=%h n=%h invalid got %b want %b", want.value_a,
                             want.modulus_n, invalid, want.invalid));
      endtask

      function int pending();
         return symbol_q.size();
      endfunction
   endclass

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     rsp_tready = 1'b0;
   logic                     req_tready;
   logic                     rsp_tvalid;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [0:0]               rsp_tuser;

   jac_scoreboard sb = new();
   int  req_count   = 0;
   int  rsp_count   = 0;
   int  idle_cycles = 0;
   bit  steady      = 1'b0;

   jacobi_symbol_64_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // transfer monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tdata);
            req_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata, rsp_tuser[0]);
            rsp_count++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // result side: random wait per item, one long hold-off
   initial begin
      int  wait_cycles;
      bit  held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && rsp_count >= HOLD_AT_RESULT) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         wait_cycles = steady ? 0 : $urandom_range(0, 9);
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // one request transfer after a random gap; valid stays up when the gap is zero
   task send_item(logic [A_BITS-1:0] a, logic [N_BITS-1:0] n);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, n, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // drop valid and wait for every pending result
   task drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // mostly narrow moduli keep the round count low
   function automatic int draw_width();
      if ($urandom_range(0, 9) < 7) return $urandom_range(1, 16);
      return $urandom_range(17, 63);
   endfunction

   function automatic logic [N_BITS-1:0] draw_modulus(int width, bit odd);
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      raw = raw & ((64'd1 << width) - 64'd1);
      raw[width-1] = 1'b1;
      raw[0] = odd;
      return raw[N_BITS-1:0];
   endfunction

   function automatic logic [A_BITS-1:0] draw_numerator(logic [N_BITS-1:0] n, int width);
      logic signed [63:0] s;
      logic [63:0]        n64;
      int                 bits;
      int                 mult;
      n64 = {1'b0, n};
      s = {$urandom, $urandom};
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7: ;
         8, 9, 10, 11: begin
            // small signed value around the modulus size
            bits = (width + 3 > 64) ? 64 : width + 3;
            s = (s <<< (64 - bits)) >>> (64 - bits);
         end
         12, 13, 14: begin
            mult = $urandom_range(0, 40) - 20;
            s = $signed(n64) * mult;
         end
         15, 16: begin
            case ($urandom_range(0, 5))
               0: s = A_MIN;
               1: s = A_MAX;
               2: s = 0;
               3: s = -1;
               4: s = -$signed(n64);
               default: s = n64 - 64'd1;
            endcase
         end
         default: if (n64 != 0) s = s[63:0] % n64;
      endcase
      return s;
   endfunction

   // stimulus
   initial begin
      int               width;
      logic [N_BITS-1:0] n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed corners: bad moduli, modulus one, multiples, extremes
      send_item(64'd0, 63'd0);
      send_item(64'd5, 63'd0);
      send_item(64'd7, 63'd2);
      send_item(-64'sd3, N_MAX - 63'd1);
      send_item(A_MIN, 63'd1);
      send_item(A_MAX, 63'd1);
      send_item(64'd0, 63'd1);
      send_item(-64'sd1, 63'd1);
      send_item(64'd0, 63'd7);
      send_item(64'd2, 63'd7);
      send_item(64'd3, 63'd7);
      send_item(-64'sd1, 63'd3);
      send_item(64'd21, 63'd7);
      send_item(-64'sd21, 63'd7);
      send_item(64'd6, 63'd15);
      send_item(-64'sd2, 63'd15);
      send_item(A_MIN, N_MAX);
      send_item(A_MAX, N_MAX);
      send_item(A_MIN, 63'd3);
      send_item(A_MAX, 63'd3);
      send_item(64'd1001, 63'd9907);
      send_item(64'd12345678901234567, 63'h7FFF_FFFF_FFFF_FFE7);
      send_item(-64'sd9223372036854775807, 63'h7FFF_FFFF_FFFF_FFE7);

      // random part, with stretches of back-to-back traffic
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
         if (i == DRAIN_AT_ITEM) drain_results();
         width = draw_width();
         if ($urandom_range(0, 99) < 12) begin
            n = ($urandom_range(0, 3) == 0) ? '0 : draw_modulus(width, 1'b0);
            send_item({$urandom, $urandom}, n);
         end else begin
            n = draw_modulus(width, 1'b1);
            send_item(draw_numerator(n, width), n);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
